@@ design/slid_pkg.sv @@
// Types and constants shared by the sorted list cell row and its controller.
package slid_pkg;

	localparam int ValueWidth = 32;
	localparam int CountWidth = 5;
	localparam int StatusWidth = 2;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} action_t;

	typedef enum logic [StatusWidth-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INSERT,
		ST_DELETE,
		ST_REPORT
	} state_t;

	typedef struct packed {
		action_t                       action;
		logic signed [ValueWidth-1:0]  value;
	} cmd_t;

	typedef struct packed {
		logic        [CountWidth-1:0]  entry_count;
		logic signed [ValueWidth-1:0]  head_value;
		logic        [CountWidth-1:0]  removed_count;
		status_t                       status;
	} result_t;

	typedef struct packed {
		logic                          ins_en;
		logic                          del_en;
		logic signed [ValueWidth-1:0]  operand;
	} cell_ctrl_t;

endpackage

@@ design/slid_cell.sv @@
// One cell of the sorted row: holds one entry, shifts right on insert, left on delete.
module slid_cell (
	input  logic                                   clk,
	input  slid_pkg::cell_ctrl_t                   ctrl,
	input  logic                                   occ,
	input  logic                                   at_end,
	input  logic signed [slid_pkg::ValueWidth-1:0] left_entry,
	input  logic                                   left_gt,
	input  logic signed [slid_pkg::ValueWidth-1:0] right_entry,
	output logic signed [slid_pkg::ValueWidth-1:0] entry,
	output logic                                   gt,
	output logic                                   eq
);

	logic signed [slid_pkg::ValueWidth-1:0] entry_q;
	logic                                   ge;

	assign gt    = occ && (entry_q > ctrl.operand);
	assign eq    = occ && (entry_q == ctrl.operand);
	assign ge    = gt || eq;
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en && (gt || at_end)) begin
			// take the left neighbour if it also moves up, else the new item lands here
			entry_q <= left_gt ? left_entry : ctrl.operand;
		end else if (ctrl.del_en && ge) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ design/sorted_list_insert_delete.sv @@
// Top level: controller and row of cells for the sorted insert/delete table.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order, one per cell
// of a row. An insert drops every larger entry one cell up, all in the same
// cycle, and puts the item after any equal values, unless the table is full;
// a delete removes one matching entry per cycle by pulling the entries above
// it one cell down, until no match is left. An insert item passes through
// its insert and report states; a delete stays in its delete state while a
// match remains, then reports. busy is high while an item is at work;
// the result is shown on result for exactly one cycle with done high and
// must be taken then, and the next item may be started in that same cycle.
module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  slid_pkg::cmd_t    cmd,
	output logic              done,
	output slid_pkg::result_t result
);

	localparam int CW = $clog2(CAPACITY + 1);

	slid_pkg::state_t   state_q, state_d;
	slid_pkg::action_t  action_q;
	logic signed [slid_pkg::ValueWidth-1:0] operand_q;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      removed_q, removed_d;
	slid_pkg::status_t  status_q, status_d;
	slid_pkg::result_t  result_q;
	logic               done_q;
	logic               report_en;

	slid_pkg::cell_ctrl_t ctrl;

	logic signed [slid_pkg::ValueWidth-1:0] entry_vec [CAPACITY];
	logic [CAPACITY-1:0] gt_vec;
	logic [CAPACITY-1:0] eq_vec;
	logic [CAPACITY-1:0] occ_vec;
	logic [CAPACITY-1:0] end_vec;
	logic                any_match;
	logic                full;

	assign any_match = |eq_vec;
	assign full      = (count_q >= CW'(CAPACITY));
	assign busy      = (state_q != slid_pkg::ST_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [slid_pkg::ValueWidth-1:0] left_entry;
		logic                                   left_gt;
		logic signed [slid_pkg::ValueWidth-1:0] right_entry;

		assign occ_vec[i] = (count_q > CW'(i));
		assign end_vec[i] = (count_q == CW'(i));

		if (i == 0) begin : g_first
			assign left_entry = ctrl.operand;
			assign left_gt    = 1'b0;
		end else begin : g_inner
			assign left_entry = entry_vec[i-1];
			assign left_gt    = gt_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			// top cell falls out of range after a removal: hold its own entry
			assign right_entry = entry_vec[i];
		end else begin : g_below
			assign right_entry = entry_vec[i+1];
		end

		slid_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ_vec[i]),
			.at_end      (end_vec[i]),
			.left_entry  (left_entry),
			.left_gt     (left_gt),
			.right_entry (right_entry),
			.entry       (entry_vec[i]),
			.gt          (gt_vec[i]),
			.eq          (eq_vec[i])
		);
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		removed_d    = removed_q;
		status_d     = status_q;
		report_en    = 1'b0;
		ctrl.ins_en  = 1'b0;
		ctrl.del_en  = 1'b0;
		ctrl.operand = operand_q;
		unique case (state_q)
			slid_pkg::ST_IDLE: begin
				if (start) begin
					removed_d = '0;
					state_d   = (cmd.action == slid_pkg::ACT_INSERT) ?
						slid_pkg::ST_INSERT : slid_pkg::ST_DELETE;
				end
			end
			slid_pkg::ST_INSERT: begin
				state_d = slid_pkg::ST_REPORT;
				if (full) begin
					status_d = slid_pkg::STATUS_FULL;
				end else begin
					ctrl.ins_en = 1'b1;
					count_d     = count_q + CW'(1);
					status_d    = slid_pkg::STATUS_OK;
				end
			end
			slid_pkg::ST_DELETE: begin
				if (any_match) begin
					// drop one match and pull the rest down
					ctrl.del_en = 1'b1;
					count_d     = count_q - CW'(1);
					removed_d   = removed_q + CW'(1);
				end else begin
					status_d = (removed_q == '0) ?
						slid_pkg::STATUS_NOT_FOUND : slid_pkg::STATUS_OK;
					state_d  = slid_pkg::ST_REPORT;
				end
			end
			slid_pkg::ST_REPORT: begin
				report_en = 1'b1;
				state_d   = slid_pkg::ST_IDLE;
			end
			default: state_d = slid_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= slid_pkg::ST_IDLE;
			count_q   <= '0;
			removed_q <= '0;
			status_q  <= slid_pkg::STATUS_OK;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
			status_q  <= status_d;
			done_q    <= report_en;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == slid_pkg::ST_IDLE && start) begin
			action_q  <= cmd.action;
			operand_q <= cmd.value;
		end
		if (report_en) begin
			result_q.entry_count   <= slid_pkg::CountWidth'(count_q);
			result_q.head_value    <= occ_vec[0] ? entry_vec[0] : '0;
			result_q.removed_count <= (action_q == slid_pkg::ACT_DELETE) ?
				slid_pkg::CountWidth'(removed_q) : '0;
			result_q.status        <= status_q;
		end
	end

endmodule
